// ===== design/kabf_pkg.sv =====
// Package: shared types and constants for the angle/bias Kalman filter.
`timescale 1ns / 1ps
package kabf_pkg;

    localparam int unsigned W = 32;

    typedef logic signed [W-1:0] t_q;

    typedef enum logic [1:0] {
        CFG_PERIOD = 2'd0,
        CFG_QANGLE = 2'd1,
        CFG_QBIAS  = 2'd2,
        CFG_RMEAS  = 2'd3
    } t_cfg_idx;

    // datapath micro-operations, one per controller step
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,       // latch item
        OP_PRED_A,     // decide update; if so angle += rate - bias
        OP_P00_A,      // t = P11 - P01
        OP_P00_B,      // t -= P10
        OP_P00_C,      // t += Qa
        OP_P00_D,      // P00 += t
        OP_P01,        // P01 -= P11, P10 -= P11, P11 += Qb
        OP_S,          // S = P00 + R, y = meas - angle
        OP_DIV0_GO,
        OP_DIV0_END,
        OP_DIV1_GO,
        OP_DIV1_END,
        OP_MUL_K0Y,
        OP_MUL_K1Y,
        OP_MUL_K0P00,
        OP_MUL_K0P01,
        OP_MUL_K1P00,
        OP_MUL_K1P01,
        OP_FINISH
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DECIDE,
        ST_PRED_A,
        ST_P00_A,
        ST_P00_B,
        ST_P00_C,
        ST_P00_D,
        ST_P01,
        ST_S,
        ST_DIV0_GO,
        ST_DIV0_WAIT,
        ST_DIV1_GO,
        ST_DIV1_WAIT,
        ST_MUL_K0Y,
        ST_MUL_K1Y,
        ST_MUL_K0P00,
        ST_MUL_K0P01,
        ST_MUL_K1P00,
        ST_MUL_K1P01,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_op  op;
        logic div_start;
    } t_cmd;

    typedef struct packed {
        logic upd;
        logic div_busy;
    } t_sts;

    function automatic t_q sat_add(input t_q a, input t_q b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        return s[W-1:0];
    endfunction

    function automatic t_q sat_sub(input t_q a, input t_q b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        return s[W-1:0];
    endfunction

endpackage

// ===== design/kabf_if.sv =====
// Valid/ready channel interfaces for items, results and configuration.
`timescale 1ns / 1ps
interface kabf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] tick_ms;
    logic signed [31:0] measured_angle;
    logic signed [31:0] measured_rate;
    modport source (output valid, tick_ms, measured_angle, measured_rate, input ready);
    modport sink   (input valid, tick_ms, measured_angle, measured_rate, output ready);
endinterface

interface kabf_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] angle_estimate;
    logic        updated;
    modport source (output valid, angle_estimate, updated, input ready);
    modport sink   (input valid, angle_estimate, updated, output ready);
endinterface

interface kabf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [30:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/kabf_div.sv =====
// Radix-2 restoring divider: sat((num * 2^16) / den), den > 0, truncated.
`timescale 1ns / 1ps
module kabf_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [31:0]  i_num,
    input  logic signed [31:0]  i_den,
    output logic                o_busy,
    output logic signed [31:0]  o_quo
);
    import kabf_pkg::*;

    localparam int unsigned NB = 48;

    logic [NB-1:0] r_dvd, n_dvd;
    logic [31:0]   r_den;
    logic [NB-1:0] r_rem, n_rem;
    logic [NB-1:0] r_quo, n_quo;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_neg;
    logic [NB:0]   w_trial;

    assign w_trial = {r_rem[NB-1:0], r_dvd[NB-1]} - {{(NB-31){1'b0}}, r_den};

    always_comb begin
        n_rem = {r_rem[NB-2:0], r_dvd[NB-1]};
        n_quo = {r_quo[NB-2:0], 1'b0};
        n_dvd = {r_dvd[NB-2:0], 1'b0};
        if (!w_trial[NB]) begin
            n_rem = w_trial[NB-1:0];
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'(NB);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[31];
            r_dvd <= {(i_num[31] ? 32'(-i_num) : 32'(i_num)), 16'd0};
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy = r_busy;

    always_comb begin
        if (r_neg) begin
            if (r_quo > 48'h8000_0000) o_quo = 32'sh8000_0000;
            else o_quo = 32'(-r_quo);
        end else begin
            if (r_quo > 48'h7FFF_FFFF) o_quo = 32'sh7FFF_FFFF;
            else o_quo = r_quo[31:0];
        end
    end

endmodule

// ===== design/kabf_dp.sv =====
// Datapath: state registers, shared multiplier, the divider and saturating adders.
`timescale 1ns / 1ps
module kabf_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kabf_pkg::t_cmd      i_cmd,
    output kabf_pkg::t_sts      o_sts,
    input  logic [31:0]         i_tick,
    input  logic signed [31:0]  i_meas,
    input  logic signed [31:0]  i_rate,
    input  logic [15:0]         i_period,
    input  logic [30:0]         i_qa,
    input  logic [30:0]         i_qb,
    input  logic [30:0]         i_r,
    output logic signed [31:0]  o_angle,
    output logic                o_upd
);
    import kabf_pkg::*;

    t_q r_angle, r_bias, r_p00, r_p01, r_p10, r_p11;
    t_q r_p00p, r_p01p;
    logic [31:0] r_last;
    t_q r_meas, r_rate, r_t, r_s, r_y, r_k0, r_k1;
    logic r_upd;
    logic [31:0] r_tick;
    logic [31:0] w_elapsed;

    t_q w_ma, w_mb, w_mq, w_quo;
    logic signed [63:0] w_prod;
    logic signed [47:0] w_sh;
    logic w_busy;

    kabf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   ((i_cmd.op == OP_DIV1_GO) ? r_p10 : r_p00),
        .i_den   (r_s),
        .o_busy  (w_busy),
        .o_quo   (w_quo)
    );

    always_comb begin
        unique case (i_cmd.op)
            OP_MUL_K0Y:   begin w_ma = r_k0; w_mb = r_y;    end
            OP_MUL_K1Y:   begin w_ma = r_k1; w_mb = r_y;    end
            OP_MUL_K0P00: begin w_ma = r_k0; w_mb = r_p00p; end
            OP_MUL_K0P01: begin w_ma = r_k0; w_mb = r_p01p; end
            OP_MUL_K1P00: begin w_ma = r_k1; w_mb = r_p00p; end
            default:      begin w_ma = r_k1; w_mb = r_p01p; end
        endcase
        w_prod = w_ma * w_mb + 64'sd32768;
        w_sh   = 48'(w_prod >>> 16);
        if (w_sh > 48'sh7FFF_FFFF) w_mq = 32'sh7FFF_FFFF;
        else if (w_sh < -48'sh8000_0000) w_mq = 32'sh8000_0000;
        else w_mq = w_sh[31:0];
    end

    assign w_elapsed = r_tick - r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0; r_bias <= '0;
            r_p00 <= '0; r_p01 <= '0; r_p10 <= '0; r_p11 <= '0;
            r_last <= '0; r_upd <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_tick <= i_tick; r_meas <= i_meas; r_rate <= i_rate;
                end
                OP_PRED_A: begin
                    r_upd <= (w_elapsed >= {16'd0, i_period});
                    if (w_elapsed >= {16'd0, i_period}) begin
                        r_last  <= r_tick;
                        r_angle <= sat_add(r_angle, sat_sub(r_rate, r_bias));
                    end
                end
                OP_P00_A: r_t <= sat_sub(r_p11, r_p01);
                OP_P00_B: r_t <= sat_sub(r_t, r_p10);
                OP_P00_C: r_t <= sat_add(r_t, {1'b0, i_qa});
                OP_P00_D: r_p00 <= sat_add(r_p00, r_t);
                OP_P01: begin
                    r_p01 <= sat_sub(r_p01, r_p11);
                    r_p10 <= sat_sub(r_p10, r_p11);
                    r_p11 <= sat_add(r_p11, {1'b0, i_qb});
                end
                OP_S: begin
                    r_s <= sat_add(r_p00, {1'b0, i_r});
                    r_y <= sat_sub(r_meas, r_angle);
                    r_p00p <= r_p00; r_p01p <= r_p01;
                    r_k0 <= '0; r_k1 <= '0;
                end
                OP_DIV0_END: if (!r_s[31] && r_s != '0) r_k0 <= w_quo;
                OP_DIV1_END: if (!r_s[31] && r_s != '0) r_k1 <= w_quo;
                OP_MUL_K0Y:   r_angle <= sat_add(r_angle, w_mq);
                OP_MUL_K1Y:   r_bias  <= sat_add(r_bias, w_mq);
                OP_MUL_K0P00: r_p00 <= sat_sub(r_p00, w_mq);
                OP_MUL_K0P01: r_p01 <= sat_sub(r_p01, w_mq);
                OP_MUL_K1P00: r_p10 <= sat_sub(r_p10, w_mq);
                OP_MUL_K1P01: r_p11 <= sat_sub(r_p11, w_mq);
                default: ;
            endcase
        end
    end

    assign o_sts.upd      = r_upd;
    assign o_sts.div_busy = w_busy;
    assign o_angle        = r_angle;
    assign o_upd          = r_upd;

endmodule

// ===== design/kabf_ctrl.sv =====
// Controller: sequences one item through the datapath.
`timescale 1ns / 1ps
module kabf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  kabf_pkg::t_sts i_sts,
    output kabf_pkg::t_cmd o_cmd
);
    import kabf_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_in_valid) n_state = ST_LOAD;
            ST_LOAD:      n_state = ST_DECIDE;
            ST_DECIDE:    n_state = ST_PRED_A;
            ST_PRED_A:    n_state = ST_P00_A;
            ST_P00_A:     n_state = i_sts.upd ? ST_P00_B : ST_OUT;
            ST_P00_B:     n_state = ST_P00_C;
            ST_P00_C:     n_state = ST_P00_D;
            ST_P00_D:     n_state = ST_P01;
            ST_P01:       n_state = ST_S;
            ST_S:         n_state = ST_DIV0_GO;
            ST_DIV0_GO:   n_state = ST_DIV0_WAIT;
            ST_DIV0_WAIT: if (!i_sts.div_busy) n_state = ST_DIV1_GO;
            ST_DIV1_GO:   n_state = ST_DIV1_WAIT;
            ST_DIV1_WAIT: if (!i_sts.div_busy) n_state = ST_MUL_K0Y;
            ST_MUL_K0Y:   n_state = ST_MUL_K1Y;
            ST_MUL_K1Y:   n_state = ST_MUL_K0P00;
            ST_MUL_K0P00: n_state = ST_MUL_K0P01;
            ST_MUL_K0P01: n_state = ST_MUL_K1P00;
            ST_MUL_K1P00: n_state = ST_MUL_K1P01;
            ST_MUL_K1P01: n_state = ST_OUT;
            ST_OUT:       if (i_out_ready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op        = OP_NONE;
        o_cmd.div_start = 1'b0;
        o_in_ready      = 1'b0;
        o_out_valid     = 1'b0;
        unique case (r_state)
            ST_IDLE:      begin o_in_ready = 1'b1; if (i_in_valid) o_cmd.op = OP_LOAD; end
            ST_DECIDE:    o_cmd.op = OP_PRED_A;
            ST_P00_A:     if (i_sts.upd) o_cmd.op = OP_P00_A;
            ST_P00_B:     o_cmd.op = OP_P00_B;
            ST_P00_C:     o_cmd.op = OP_P00_C;
            ST_P00_D:     o_cmd.op = OP_P00_D;
            ST_P01:       o_cmd.op = OP_P01;
            ST_S:         o_cmd.op = OP_S;
            ST_DIV0_GO:   begin o_cmd.op = OP_DIV0_GO; o_cmd.div_start = 1'b1; end
            ST_DIV0_WAIT: if (!i_sts.div_busy) o_cmd.op = OP_DIV0_END;
            ST_DIV1_GO:   begin o_cmd.op = OP_DIV1_GO; o_cmd.div_start = 1'b1; end
            ST_DIV1_WAIT: if (!i_sts.div_busy) o_cmd.op = OP_DIV1_END;
            ST_MUL_K0Y:   o_cmd.op = OP_MUL_K0Y;
            ST_MUL_K1Y:   o_cmd.op = OP_MUL_K1Y;
            ST_MUL_K0P00: o_cmd.op = OP_MUL_K0P00;
            ST_MUL_K0P01: o_cmd.op = OP_MUL_K0P01;
            ST_MUL_K1P00: o_cmd.op = OP_MUL_K1P00;
            ST_MUL_K1P01: o_cmd.op = OP_MUL_K1P01;
            ST_OUT:       o_out_valid = 1'b1;
            default:      ;
        endcase
    end

endmodule

// ===== design/kalman_angle_bias_filter.sv =====
// Top level of the two-state angle/gyro-bias Kalman filter.
// Usage:
//   i_in carries one beat per sensor sample (tick, angle, rate), i_cfg writes
//   the period and noise registers (index 0..3), o_out returns one beat per
//   input beat: the angle estimate and whether the filter updated.
// Flow: an item that does not update goes from LOAD through DECIDE, PRED_A
//   and P00_A straight to OUT; an update runs the prediction, two 48-step
//   divisions on one shared divider and six products on one shared
//   multiplier before OUT. One item is in flight at a time; the next beat is
//   taken in the cycle after the result leaves.
// Reset (synchronous, active low) clears angle, bias, covariance and the last
//   update tick and loads the register defaults.
// While o_out is stalled the result holds and no new beat is taken.
// The user writes configuration only while the block is idle; the block itself does not enforce it.
`timescale 1ns / 1ps
module kalman_angle_bias_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kabf_in_if.sink    i_in,
    kabf_cfg_if.sink   i_cfg,
    kabf_out_if.source o_out
);
    import kabf_pkg::*;

    logic [15:0] r_period;
    logic [30:0] r_qa, r_qb, r_r;
    t_cmd w_cmd;
    t_sts w_sts;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 16'd1;
            r_qa <= 31'd66;
            r_qb <= 31'd197;
            r_r  <= 31'd1966;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_PERIOD: r_period <= i_cfg.data[15:0];
                CFG_QANGLE: r_qa <= i_cfg.data;
                CFG_QBIAS:  r_qb <= i_cfg.data;
                CFG_RMEAS:  r_r  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    kabf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    kabf_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_tick   (i_in.tick_ms),
        .i_meas   (i_in.measured_angle),
        .i_rate   (i_in.measured_rate),
        .i_period (r_period),
        .i_qa     (r_qa),
        .i_qb     (r_qb),
        .i_r      (r_r),
        .o_angle  (o_out.angle_estimate),
        .o_upd    (o_out.updated)
    );

endmodule
